// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held low.
`define KL_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define KL_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ===== rtl/klstk_pkg.sv =====
// ----------------------------------------------------------------------------
// Keyed LIFO stack package
// Shared widths, action and status codes, and the cell control bundle.
// ----------------------------------------------------------------------------
package klstk_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int CODE_W    = 32;
    localparam int ACT_W     = 2;
    localparam int STATUS_W  = 3;
    localparam int FILL_W    = 5;
    localparam int CAP_W     = 5;
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 40;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [ACT_W-1:0] ACT_LIST   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FIND   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_ADD    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DUP       = 3'd4;

    typedef struct packed {
        logic clear;
        logic search_en;
        logic shift_en;
        logic write_en;
    } klstk_ctrl_t;

endpackage

// ===== rtl/klstk_cell.sv =====
// ----------------------------------------------------------------------------
// Keyed LIFO stack cell
// Holds one stack entry and a search flag; the flag ripples upward one cell
// per cycle and marks the cells at or above a matching entry.
// ----------------------------------------------------------------------------
module klstk_cell
    import klstk_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  klstk_ctrl_t       ctrl,
    input  logic [CNT_W-1:0]  count,
    input  logic [CODE_W-1:0] key,
    input  logic              flag_in,
    input  logic [CODE_W-1:0] entry_in,
    output logic [CODE_W-1:0] entry,
    output logic              flag
);

    logic [CODE_W-1:0] entry_reg, entry_next;
    logic              flag_reg, flag_next;
    logic              occupied;
    logic              write_here;

    assign occupied   = CNT_W'(IDX) < count;
    assign write_here = count == CNT_W'(IDX);

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.write_en && write_here) begin
            entry_next = key;
        end else if (ctrl.shift_en && flag_reg) begin
            entry_next = entry_in;
        end
    end

    always_comb begin
        flag_next = flag_reg;
        if (ctrl.clear) begin
            flag_next = 1'b0;
        end else if (ctrl.search_en) begin
            flag_next = flag_in | (occupied && (entry_reg == key));
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_reg <= 1'b0;
        end else begin
            flag_reg <= flag_next;
        end
    end

    assign entry = entry_reg;
    assign flag  = flag_reg;

endmodule

// ===== rtl/keyed_lifo_stack.sv =====
// ----------------------------------------------------------------------------
// Keyed LIFO stack
// Bounded stack of unique codes with list, find, keyed remove and add,
// built as a chain of entry cells under a small sequencer.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// s_        in         tdata: action, code
// m_        out        tdata: status, item_code, fill_count; tlast: last
// cfg_      in         capacity write
//
// Find, remove and add walk the match flag up the cell chain one cell per
// cycle in the search state, then a resolve and an emit state follow.
// List emits the stored codes top first; refused requests go straight to emit.
// Reset clears the count and sets the capacity to 16; entries are not cleared.
// Output stalls hold the sequencer; a new transfer is taken while the last
// result still waits in the output register.
// ----------------------------------------------------------------------------
module keyed_lifo_stack
    import klstk_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // action[1:0], code[33:2], zero pad
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // status[2:0], item_code[34:3],
                                           // fill_count[39:35]
    output logic                m_tlast,
    input  logic                cfg_wen,
    input  logic [CAP_W-1:0]    cfg_wdata
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SEARCH  = 3'd1;
    localparam logic [2:0] S_RESOLVE = 3'd2;
    localparam logic [2:0] S_EMIT    = 3'd3;
    localparam logic [2:0] S_LIST    = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CAP_W-1:0]    cap_reg, cap_next;
    logic [CODE_W-1:0]   key_reg, key_next;
    logic [ACT_W-1:0]    act_reg, act_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [IDX_W-1:0]    srch_cnt_reg, srch_cnt_next;
    logic [IDX_W-1:0]    list_idx_reg, list_idx_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                m_tlast_reg, m_tlast_next;

    klstk_ctrl_t         ctrl;
    logic [CODE_W-1:0]   cell_entry [DEPTH];
    logic [DEPTH-1:0]    cell_flag;
    logic [ACT_W-1:0]    in_action;
    logic [CODE_W-1:0]   in_code;
    logic [CMP_W-1:0]    cap_ext;
    logic [CMP_W-1:0]    cap_eff;
    logic                is_full;
    logic                found;
    logic                out_free;

    assign in_action = s_tdata[ACT_W-1:0];
    assign in_code   = s_tdata[ACT_W+CODE_W-1:ACT_W];

    assign cap_ext  = CMP_W'(cap_reg);
    assign cap_eff  = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
    assign is_full  = CMP_W'(count_reg) >= cap_eff;
    assign found    = cell_flag[DEPTH-1];
    assign out_free = !m_tvalid_reg || m_tready;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic              flag_in;
        logic [CODE_W-1:0] entry_in;

        if (i == 0) begin : g_bottom
            assign flag_in = 1'b0;
        end else begin : g_inner
            assign flag_in = cell_flag[i-1];
        end

        if (i == DEPTH - 1) begin : g_top
            assign entry_in = cell_entry[i];
        end else begin : g_below
            assign entry_in = cell_entry[i+1];
        end

        klstk_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .count    (count_reg),
            .key      (key_reg),
            .flag_in  (flag_in),
            .entry_in (entry_in),
            .entry    (cell_entry[i]),
            .flag     (cell_flag[i])
        );
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        cap_next      = cap_reg;
        key_next      = key_reg;
        act_next      = act_reg;
        status_next   = status_reg;
        srch_cnt_next = srch_cnt_reg;
        list_idx_next = list_idx_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        ctrl          = '0;

        if (cfg_wen) begin
            cap_next = cfg_wdata;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    key_next      = in_code;
                    act_next      = in_action;
                    srch_cnt_next = '0;
                    ctrl.clear    = 1'b1;
                    unique case (in_action) inside
                        ACT_LIST: begin
                            if (count_reg == '0) begin
                                status_next = ST_EMPTY;
                                state_next  = S_EMIT;
                            end else begin
                                list_idx_next = IDX_W'(count_reg - 1'b1);
                                state_next    = S_LIST;
                            end
                        end
                        ACT_FIND, ACT_REMOVE: begin
                            if (count_reg == '0) begin
                                status_next = ST_EMPTY;
                                state_next  = S_EMIT;
                            end else begin
                                state_next = S_SEARCH;
                            end
                        end
                        ACT_ADD: begin
                            if (is_full) begin
                                status_next = ST_FULL;
                                state_next  = S_EMIT;
                            end else begin
                                state_next = S_SEARCH;
                            end
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                ctrl.search_en = 1'b1;
                srch_cnt_next  = srch_cnt_reg + 1'b1;
                if (srch_cnt_reg == IDX_W'(DEPTH - 1)) begin
                    state_next = S_RESOLVE;
                end
            end
            S_RESOLVE: begin
                state_next = S_EMIT;
                unique case (act_reg) inside
                    ACT_REMOVE: begin
                        if (found) begin
                            ctrl.shift_en = 1'b1;
                            count_next    = count_reg - 1'b1;
                            status_next   = ST_OK;
                        end else begin
                            status_next = ST_NOT_FOUND;
                        end
                    end
                    ACT_ADD: begin
                        if (found) begin
                            status_next = ST_DUP;
                        end else begin
                            ctrl.write_en = 1'b1;
                            count_next    = count_reg + 1'b1;
                            status_next   = ST_OK;
                        end
                    end
                    default: begin
                        status_next = found ? ST_OK : ST_NOT_FOUND;
                    end
                endcase
            end
            S_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {FILL_W'(count_reg), {CODE_W{1'b0}}, status_reg};
                    m_tlast_next  = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_LIST: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {FILL_W'(count_reg), cell_entry[list_idx_reg], ST_OK};
                    m_tlast_next  = list_idx_reg == '0;
                    if (list_idx_reg == '0) begin
                        state_next = S_IDLE;
                    end else begin
                        list_idx_next = list_idx_reg - 1'b1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            cap_reg      <= CAP_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            cap_reg      <= cap_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg      <= key_next;
        act_reg      <= act_next;
        status_reg   <= status_next;
        srch_cnt_reg <= srch_cnt_next;
        list_idx_reg <= list_idx_next;
        m_tdata_reg  <= m_tdata_next;
        m_tlast_reg  <= m_tlast_next;
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ===== rtl/klstk_checker.sv =====
// ----------------------------------------------------------------------------
// Keyed LIFO stack checker
// Port-level assertions on the result channel and input ready, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module klstk_checker
    import klstk_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                m_tlast
);

    `KL_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_tvalid && s_tready)
    `KL_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    `KL_ASSERT(a_fail_is_last, aclk, aresetn, m_tvalid && m_tdata[2:0] != ST_OK |-> m_tlast)
    `KL_ASSERT(a_fail_no_item, aclk, aresetn, m_tvalid && m_tdata[2:0] != ST_OK |-> m_tdata[34:3] == '0)
    `KL_ASSERT(a_status_code, aclk, aresetn, m_tvalid |-> m_tdata[2:0] <= ST_DUP)

endmodule

bind keyed_lifo_stack klstk_checker u_klstk_checker (.*);

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// Keyed LIFO stack testbench
// Drives list, find, remove and add requests into the stack over the input
// stream. Each accepted reply is checked against a behavioral copy of the
// stack, or against replies typed into the directed table. A directed table
// comes first, then random phases at several capacities. Both sides idle at
// random, except in one steady phase.
// ----------------------------------------------------------------------------
module tb;
    import klstk_pkg::*;

    localparam int STK_DEPTH = DEPTH_DEF;
    localparam int WATCHDOG  = 4000;
    localparam int N_DIR     = 26;
    localparam int N_PHASE   = 7;
    localparam int PHASE_LEN = 18;
    localparam int POOL_SZ   = 24;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CODE_W-1:0]   item;
        logic [FILL_W-1:0]   fill;
        logic                last;
    } reply_t;

    typedef struct packed {
        logic   typed;
        reply_t want;
    } fixed_reply_t;

    typedef struct {
        int                  cap;
        logic [ACT_W-1:0]    act;
        logic [CODE_W-1:0]   code;
        bit                  typed;
        logic [STATUS_W-1:0] status;
        logic [FILL_W-1:0]   fill;
    } dir_row_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b1;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;
    logic                cfg_wen   = 1'b0;
    logic [CAP_W-1:0]    cfg_wdata = '0;

    logic [CODE_W-1:0] stack_mem [0:STK_DEPTH-1];
    int                stack_fill = 0;
    logic [CAP_W-1:0]  stack_cap  = CAP_RESET;

    reply_t       due_q [$];
    reply_t       step_out [$];
    fixed_reply_t fixed_q [$];

    bit                steady = 1'b0;
    int                mismatches = 0;
    int                checked = 0;
    int                deepest = 0;
    int                cfg_writes = 0;
    int                act_seen [0:3] = '{0, 0, 0, 0};
    int                idle_cycles = 0;
    logic [CODE_W-1:0] pool [0:POOL_SZ-1];

    dir_row_t dir_tab [0:N_DIR-1] = '{
        '{-1, ACT_LIST,   32'h0000_0000, 1'b1, ST_EMPTY,     5'd0},
        '{-1, ACT_FIND,   32'h0000_0000, 1'b1, ST_EMPTY,     5'd0},
        '{-1, ACT_REMOVE, 32'h0000_0005, 1'b1, ST_EMPTY,     5'd0},
        '{-1, ACT_ADD,    32'h8000_0000, 1'b1, ST_OK,        5'd1},
        '{-1, ACT_ADD,    32'h7FFF_FFFF, 1'b1, ST_OK,        5'd2},
        '{-1, ACT_ADD,    32'h0000_0000, 1'b1, ST_OK,        5'd3},
        '{-1, ACT_ADD,    32'hFFFF_FFFF, 1'b1, ST_OK,        5'd4},
        '{-1, ACT_ADD,    32'h7FFF_FFFF, 1'b1, ST_DUP,       5'd4},
        '{-1, ACT_FIND,   32'h0000_0000, 1'b1, ST_OK,        5'd4},
        '{-1, ACT_FIND,   32'h0000_3039, 1'b1, ST_NOT_FOUND, 5'd4},
        '{-1, ACT_LIST,   32'h0000_0000, 1'b0, ST_OK,        5'd0},
        '{-1, ACT_REMOVE, 32'h7FFF_FFFF, 1'b1, ST_OK,        5'd3},
        '{-1, ACT_LIST,   32'h0000_0000, 1'b0, ST_OK,        5'd0},
        '{-1, ACT_REMOVE, 32'h0000_03E7, 1'b1, ST_NOT_FOUND, 5'd3},
        '{-1, ACT_REMOVE, 32'hFFFF_FFFF, 1'b1, ST_OK,        5'd2},
        '{-1, ACT_ADD,    32'h5555_5555, 1'b1, ST_OK,        5'd3},
        '{ 1, ACT_ADD,    32'h0000_004D, 1'b1, ST_FULL,      5'd3},
        '{-1, ACT_ADD,    32'h0000_0000, 1'b1, ST_FULL,      5'd3},
        '{-1, ACT_REMOVE, 32'h8000_0000, 1'b1, ST_OK,        5'd2},
        '{-1, ACT_REMOVE, 32'h0000_0000, 1'b1, ST_OK,        5'd1},
        '{-1, ACT_ADD,    32'h5555_5555, 1'b1, ST_FULL,      5'd1},
        '{-1, ACT_REMOVE, 32'h5555_5555, 1'b1, ST_OK,        5'd0},
        '{-1, ACT_ADD,    32'hAAAA_AAAA, 1'b1, ST_OK,        5'd1},
        '{ 0, ACT_ADD,    32'h0000_0003, 1'b1, ST_FULL,      5'd1},
        '{31, ACT_ADD,    32'h0000_0003, 1'b1, ST_OK,        5'd2},
        '{-1, ACT_LIST,   32'h7FFF_FFFF, 1'b0, ST_OK,        5'd0}
    };

    int phase_cap [0:N_PHASE-1] = '{31, 16, 3, 0, 1, 8, 16};
    int phase_add [0:N_PHASE-1] = '{80, 50, 45, 40, 45, 50, 20};

    keyed_lifo_stack uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    task automatic push_reply(input logic [STATUS_W-1:0] status,
                              input logic [CODE_W-1:0] item, input logic last);
        reply_t r;
        r.status = status;
        r.item   = item;
        r.fill   = stack_fill[FILL_W-1:0];
        r.last   = last;
        step_out.push_back(r);
    endtask

    task automatic apply_request(input logic [ACT_W-1:0] act,
                                 input logic [CODE_W-1:0] code);
        int pos;
        int eff;
        pos = -1;
        for (int i = 0; i < stack_fill; i++)
            if (pos < 0 && stack_mem[i] == code) pos = i;
        eff = (stack_cap > STK_DEPTH) ? STK_DEPTH : int'(stack_cap);
        case (act)
            ACT_LIST: begin
                if (stack_fill == 0) begin
                    push_reply(ST_EMPTY, '0, 1'b1);
                end else begin
                    for (int i = 0; i < stack_fill; i++)
                        push_reply(ST_OK, stack_mem[stack_fill-1-i],
                                   i == stack_fill - 1);
                end
            end
            ACT_FIND: begin
                if (stack_fill == 0) push_reply(ST_EMPTY, '0, 1'b1);
                else push_reply((pos >= 0) ? ST_OK : ST_NOT_FOUND, '0, 1'b1);
            end
            ACT_REMOVE: begin
                if (stack_fill == 0) begin
                    push_reply(ST_EMPTY, '0, 1'b1);
                end else if (pos < 0) begin
                    push_reply(ST_NOT_FOUND, '0, 1'b1);
                end else begin
                    for (int i = pos; i + 1 < stack_fill; i++)
                        stack_mem[i] = stack_mem[i+1];
                    stack_fill--;
                    push_reply(ST_OK, '0, 1'b1);
                end
            end
            default: begin
                if (stack_fill >= eff) begin
                    push_reply(ST_FULL, '0, 1'b1);
                end else if (pos >= 0) begin
                    push_reply(ST_DUP, '0, 1'b1);
                end else begin
                    stack_mem[stack_fill] = code;
                    stack_fill++;
                    push_reply(ST_OK, '0, 1'b1);
                end
            end
        endcase
    endtask

    task automatic note_mismatch(input string what, input reply_t want, input reply_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch (%s): exp status %0d item %h fill %0d last %b",
                     what, want.status, want.item, want.fill, want.last);
            $display("    got status %0d item %h fill %0d last %b",
                     got.status, got.item, got.fill, got.last);
        end
    endtask

    always @(posedge aclk) begin
        fixed_reply_t fx;
        reply_t       got;
        reply_t       want;
        if (aresetn) begin
            if (cfg_wen) begin
                stack_cap = cfg_wdata;
                cfg_writes++;
            end
            if (s_tvalid && s_tready) begin
                apply_request(s_tdata[1:0], s_tdata[33:2]);
                act_seen[s_tdata[1:0]]++;
                if (stack_fill > deepest) deepest = stack_fill;
                fx = fixed_q.pop_front();
                if (fx.typed) due_q.push_back(fx.want);
                else foreach (step_out[i]) due_q.push_back(step_out[i]);
                step_out.delete();
            end
            if (m_tvalid && m_tready) begin
                got.status = m_tdata[2:0];
                got.item   = m_tdata[34:3];
                got.fill   = m_tdata[39:35];
                got.last   = m_tlast;
                checked++;
                if (due_q.size() == 0) begin
                    note_mismatch("unexpected reply", '0, got);
                end else begin
                    want = due_q.pop_front();
                    if (got !== want) note_mismatch("field", want, got);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("watchdog: no transfer for %0d cycles", WATCHDOG);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        int stall;
        forever begin
            stall = steady ? 0 : $urandom_range(0, 13);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
                m_tready <= 1'b1;
            end
            do @(posedge aclk); while (!(m_tvalid && m_tready && aresetn));
        end
    end

    task automatic send_request(input logic [ACT_W-1:0] act, input logic [CODE_W-1:0] code,
                                input bit typed, input reply_t want);
        int           gap;
        fixed_reply_t fx;
        gap = steady ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        fx.typed = typed;
        fx.want  = want;
        fixed_q.push_back(fx);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W-CODE_W-ACT_W){1'b0}}, code, act};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (due_q.size() != 0) @(posedge aclk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] value);
        drain();
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
    endtask

    initial begin
        reply_t           want;
        logic [ACT_W-1:0] act;
        logic [CODE_W-1:0] code;
        int               r;
        pool[0] = 32'h8000_0000;
        pool[1] = 32'h7FFF_FFFF;
        pool[2] = 32'h0000_0000;
        pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < POOL_SZ; i++) pool[i] = $urandom;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_DIR; i++) begin
            if (dir_tab[i].cap >= 0) set_capacity(dir_tab[i].cap[CAP_W-1:0]);
            want.status = dir_tab[i].status;
            want.item   = '0;
            want.fill   = dir_tab[i].fill;
            want.last   = 1'b1;
            send_request(dir_tab[i].act, dir_tab[i].code, dir_tab[i].typed, want);
        end

        for (int p = 0; p < N_PHASE; p++) begin
            set_capacity(phase_cap[p][CAP_W-1:0]);
            steady = (p == 3);
            for (int i = 0; i < PHASE_LEN; i++) begin
                if (p == 1 && i == PHASE_LEN / 2) drain();
                r = $urandom_range(0, 99);
                if (r < phase_add[p]) begin
                    act = ACT_ADD;
                end else begin
                    r = $urandom_range(0, 9);
                    act = (r < 2) ? ACT_LIST : (r < 6) ? ACT_FIND : ACT_REMOVE;
                end
                code = ($urandom_range(0, 9) == 0) ? $urandom
                                                   : pool[$urandom_range(0, POOL_SZ - 1)];
                send_request(act, code, 1'b0, '0);
            end
        end
        steady = 1'b0;

        drain();
        repeat (STK_DEPTH + 8) @(posedge aclk);
        $display("covered %0d list, %0d find, %0d remove, %0d add, %0d capacity writes",
                 act_seen[ACT_LIST], act_seen[ACT_FIND], act_seen[ACT_REMOVE],
                 act_seen[ACT_ADD], cfg_writes);
        $display("%0d replies checked, deepest fill %0d, %0d mismatches",
                 checked, deepest, mismatches);
        if (mismatches == 0 && due_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/klstk_pkg.sv
rtl/klstk_cell.sv
rtl/keyed_lifo_stack.sv
rtl/klstk_checker.sv
dv/tb.sv
